>>> rtl/wtm_pkg.sv
// Shared widths, constants and handshake structs for the windowed throughput meter.
package wtm_pkg;

    localparam int DEFAULT_HISTORY_DEPTH = 32;
    localparam int DEFAULT_DISK_COUNT    = 4;
    localparam int MAX_DISKS             = 4;

    localparam int KB_W        = 32;
    localparam int SUM_W       = 34;
    localparam int INTERVAL_W  = 16;
    localparam int SCALE_W     = 10;
    localparam int DELTA_W     = 32;
    localparam int DIVIDEND_W  = DELTA_W + SCALE_W;
    // Window divisor is fill count (up to 11 bits at the largest ring) times the interval.
    localparam int DIVISOR_W   = 11 + INTERVAL_W;
    localparam int STEP_W      = $clog2(DIVIDEND_W);

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);
    localparam logic [SCALE_W-1:0]    MS_PER_SEC     = SCALE_W'(1000);

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DELTA_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/wtm_if.sv
// Snapshot input and rate result channel interfaces.
interface wtm_snap_if;
    logic        valid;
    logic        ready;
    logic [31:0] disk0_read_kb;
    logic [31:0] disk0_write_kb;
    logic [31:0] disk1_read_kb;
    logic [31:0] disk1_write_kb;
    logic [31:0] disk2_read_kb;
    logic [31:0] disk2_write_kb;
    logic [31:0] disk3_read_kb;
    logic [31:0] disk3_write_kb;
    logic [31:0] net_upload_kb;
    logic [31:0] net_download_kb;

    modport source (
        output valid, disk0_read_kb, disk0_write_kb, disk1_read_kb, disk1_write_kb,
               disk2_read_kb, disk2_write_kb, disk3_read_kb, disk3_write_kb,
               net_upload_kb, net_download_kb,
        input  ready
    );

    modport sink (
        input  valid, disk0_read_kb, disk0_write_kb, disk1_read_kb, disk1_write_kb,
               disk2_read_kb, disk2_write_kb, disk3_read_kb, disk3_write_kb,
               net_upload_kb, net_download_kb,
        output ready
    );
endinterface

interface wtm_rate_if;
    logic        valid;
    logic        ready;
    logic        rates_valid;
    logic [33:0] disk_read_total_kb;
    logic [33:0] disk_write_total_kb;
    logic [31:0] disk_read_avg_rate;
    logic [31:0] disk_write_avg_rate;
    logic [31:0] upload_avg_rate;
    logic [31:0] download_avg_rate;
    logic [31:0] upload_now_rate;
    logic [31:0] download_now_rate;

    modport source (
        output valid, rates_valid, disk_read_total_kb, disk_write_total_kb,
               disk_read_avg_rate, disk_write_avg_rate, upload_avg_rate,
               download_avg_rate, upload_now_rate, download_now_rate,
        input  ready
    );

    modport sink (
        input  valid, rates_valid, disk_read_total_kb, disk_write_total_kb,
               disk_read_avg_rate, disk_write_avg_rate, upload_avg_rate,
               download_avg_rate, upload_now_rate, download_now_rate,
        output ready
    );
endinterface

>>> rtl/windowed_throughput_meter.sv
// Top level: snapshot ring, sequencer and shared rate divider.
//
//  channel    dir  handshake            carries
//  snap       in   valid/ready          ten cumulative KB counters
//  rates      out  valid/ready          totals, four window rates, two instant rates
//  cfg        in   cfg_we/cfg_wdata     sample_interval_ms, no read-back
//
// The six rate divisions run one after another through a single bit-serial divider,
// one step for each of the 42 dividend bits.
// Snapshots with fewer than two stored entries skip the divisions and load zeroed results.
// Reset clears the write pointer and fill count and sets the interval to 1000 ms; ring contents are not cleared.
// snap.ready is high only between snapshots; a result waiting on rates does not block
// the next snapshot until its results are ready to be loaded.
module windowed_throughput_meter
    import wtm_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH,
    parameter int DISK_COUNT    = DEFAULT_DISK_COUNT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [INTERVAL_W-1:0] cfg_wdata,
    wtm_snap_if.sink              snap,
    wtm_rate_if.source            rates
);

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);

    typedef struct packed {
        logic [SUM_W-1:0] rd_sum;
        logic [SUM_W-1:0] wr_sum;
        logic [KB_W-1:0]  up;
        logic [KB_W-1:0]  dn;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE, S_OLD, S_PREV, S_LOAD, S_MUL, S_START, S_WAIT, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_RD_AVG, OP_WR_AVG, OP_UP_AVG, OP_DN_AVG, OP_UP_NOW, OP_DN_NOW
    } op_t;

    entry_t ring_mem [HISTORY_DEPTH];
    entry_t ring_rdata_reg;
    logic [ADDR_W-1:0] rd_addr;

    state_t state_reg;
    op_t    op_reg;

    logic [INTERVAL_W-1:0] interval_reg;
    logic [ADDR_W-1:0]     write_slot_reg;
    logic [ADDR_W-1:0]     write_slot_next;
    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;
    logic [ADDR_W-1:0]     oldest_reg;
    logic [ADDR_W-1:0]     prev_reg;
    logic                  valid_reg;

    entry_t                cur_reg;
    entry_t                old_reg;
    logic [KB_W-1:0]       prev_up_reg;
    logic [KB_W-1:0]       prev_dn_reg;
    logic [DIVISOR_W-1:0]  win_div_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVIDEND_W-1:0] product_reg;
    logic [DELTA_W-1:0]    rate_reg [6];

    logic                  out_valid_reg;
    logic                  out_rates_valid_reg;
    logic [SUM_W-1:0]      out_rd_total_reg;
    logic [SUM_W-1:0]      out_wr_total_reg;
    logic [DELTA_W-1:0]    out_rate_reg [6];

    logic [SUM_W-1:0]      rd_sum;
    logic [SUM_W-1:0]      wr_sum;
    logic [KB_W-1:0]       rd_kb [MAX_DISKS];
    logic [KB_W-1:0]       wr_kb [MAX_DISKS];
    logic [INTERVAL_W-1:0] interval_eff;
    logic [DELTA_W-1:0]    delta;
    logic                  snap_xfer;
    logic                  out_free;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign snap.ready = (state_reg == S_IDLE);
    assign snap_xfer  = snap.valid && snap.ready;
    assign out_free   = !out_valid_reg || rates.ready;

    assign interval_eff = (interval_reg == '0) ? INTERVAL_W'(1) : interval_reg;

    always_comb begin
        rd_kb[0] = snap.disk0_read_kb;
        rd_kb[1] = snap.disk1_read_kb;
        rd_kb[2] = snap.disk2_read_kb;
        rd_kb[3] = snap.disk3_read_kb;
        wr_kb[0] = snap.disk0_write_kb;
        wr_kb[1] = snap.disk1_write_kb;
        wr_kb[2] = snap.disk2_write_kb;
        wr_kb[3] = snap.disk3_write_kb;
    end

    always_comb begin
        rd_sum = '0;
        wr_sum = '0;
        for (int i = 0; i < MAX_DISKS; i++) begin
            if (i < DISK_COUNT)
            begin
                rd_sum = rd_sum + SUM_W'(rd_kb[i]);
                wr_sum = wr_sum + SUM_W'(wr_kb[i]);
            end
        end
    end

    assign write_slot_next = (write_slot_reg == ADDR_W'(HISTORY_DEPTH - 1))
                             ? '0 : write_slot_reg + ADDR_W'(1);
    assign fill_next = (fill_reg < CNT_W'(HISTORY_DEPTH)) ? fill_reg + CNT_W'(1) : fill_reg;

    // Disk deltas are the low 32 bits of the 34-bit sum difference.
    always_comb begin
        case (op_reg)
            OP_RD_AVG: delta = cur_reg.rd_sum[DELTA_W-1:0] - old_reg.rd_sum[DELTA_W-1:0];
            OP_WR_AVG: delta = cur_reg.wr_sum[DELTA_W-1:0] - old_reg.wr_sum[DELTA_W-1:0];
            OP_UP_AVG: delta = cur_reg.up - old_reg.up;
            OP_DN_AVG: delta = cur_reg.dn - old_reg.dn;
            OP_UP_NOW: delta = cur_reg.up - prev_up_reg;
            OP_DN_NOW: delta = cur_reg.dn - prev_dn_reg;
            default:   delta = '0;
        endcase
    end

    assign rd_addr = (state_reg == S_OLD) ? oldest_reg : prev_reg;

    always_ff @(posedge clk) begin
        if (snap_xfer)
        begin
            ring_mem[write_slot_reg] <= '{rd_sum: rd_sum, wr_sum: wr_sum,
                                          up: snap.net_upload_kb, dn: snap.net_download_kb};
        end
        ring_rdata_reg <= ring_mem[rd_addr];
    end

    assign div_req.start    = (state_reg == S_START);
    assign div_req.dividend = product_reg;
    assign div_req.divisor  = divisor_reg;

    wtm_rate_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_RD_AVG;
            interval_reg <= INTERVAL_RESET;
            write_slot_reg <= '0;
            fill_reg <= '0;
            valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                interval_reg <= cfg_wdata;
            end

            // in S_DONE the load below owns out_valid_reg
            if (out_valid_reg && rates.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (snap_xfer)
                    begin
                        cur_reg <= '{rd_sum: rd_sum, wr_sum: wr_sum,
                                     up: snap.net_upload_kb, dn: snap.net_download_kb};
                        write_slot_reg <= write_slot_next;
                        fill_reg <= fill_next;
                        prev_reg <= (write_slot_reg == '0)
                                    ? ADDR_W'(HISTORY_DEPTH - 1) : write_slot_reg - ADDR_W'(1);
                        oldest_reg <= (fill_next < CNT_W'(HISTORY_DEPTH)) ? '0 : write_slot_next;
                        valid_reg <= (fill_next >= CNT_W'(2));
                        state_reg <= (fill_next >= CNT_W'(2)) ? S_OLD : S_DONE;
                    end
                end
                S_OLD:
                begin
                    win_div_reg <= DIVISOR_W'(fill_reg * interval_eff);
                    state_reg <= S_PREV;
                end
                S_PREV:
                begin
                    old_reg <= ring_rdata_reg;
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    prev_up_reg <= ring_rdata_reg.up;
                    prev_dn_reg <= ring_rdata_reg.dn;
                    op_reg <= OP_RD_AVG;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    product_reg <= DIVIDEND_W'(delta) * DIVIDEND_W'(MS_PER_SEC);
                    divisor_reg <= (op_reg == OP_UP_NOW || op_reg == OP_DN_NOW)
                                   ? DIVISOR_W'(interval_eff) : win_div_reg;
                    state_reg <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        rate_reg[op_reg] <= div_rsp.quotient;
                        if (op_reg == OP_DN_NOW)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            op_reg <= op_t'(op_reg + 3'd1);
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_rates_valid_reg <= valid_reg;
                        out_rd_total_reg <= valid_reg ? cur_reg.rd_sum : '0;
                        out_wr_total_reg <= valid_reg ? cur_reg.wr_sum : '0;
                        for (int i = 0; i < 6; i++) begin
                            out_rate_reg[i] <= valid_reg ? rate_reg[i] : '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rates.valid               = out_valid_reg;
    assign rates.rates_valid         = out_rates_valid_reg;
    assign rates.disk_read_total_kb  = out_rd_total_reg;
    assign rates.disk_write_total_kb = out_wr_total_reg;
    assign rates.disk_read_avg_rate  = out_rate_reg[OP_RD_AVG];
    assign rates.disk_write_avg_rate = out_rate_reg[OP_WR_AVG];
    assign rates.upload_avg_rate     = out_rate_reg[OP_UP_AVG];
    assign rates.download_avg_rate   = out_rate_reg[OP_DN_AVG];
    assign rates.upload_now_rate     = out_rate_reg[OP_UP_NOW];
    assign rates.download_now_rate   = out_rate_reg[OP_DN_NOW];

endmodule

>>> rtl/wtm_rate_div.sv
// Restoring divider, one quotient bit per cycle, saturating the quotient to 32 bits.
module wtm_rate_div
    import wtm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     count_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            count_reg <= STEP_W'(DIVIDEND_W - 1);
        end
        else if (busy_reg)
        begin
            if (count_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg - STEP_W'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk) begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = (|quo_reg[DIVIDEND_W-1:DELTA_W]) ? '1 : quo_reg[DELTA_W-1:0];

endmodule
